>>> hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared constants, result kinds and structs of the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    // capacities of the limit registers
    localparam int LINE_CAP    = 128;
    localparam int ARG_LEN_CAP = 16;
    localparam int ARGS_CAP    = 8;

    // field widths
    localparam int CH_W      = 8;
    localparam int LINE_W    = 8;
    localparam int ARG_LEN_W = 5;
    localparam int ARGS_W    = 4;
    localparam int ASLOT_W   = 3;
    localparam int CSLOT_W   = 4;
    localparam int COUNT_W   = 4;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int M_DATA_W  = 24;

    // register reset values, clamped to the capacities
    localparam int MAX_LINE_LEN_RST = 128;
    localparam int MAX_ARG_LEN_RST  = 16;
    localparam int MAX_ARGS_RST     = 8;
    localparam logic [LINE_W-1:0] LINE_LIM_RST =
        LINE_W'((MAX_LINE_LEN_RST < LINE_CAP) ? MAX_LINE_LEN_RST : LINE_CAP);
    localparam logic [ARG_LEN_W-1:0] ARG_LEN_LIM_RST =
        ARG_LEN_W'((MAX_ARG_LEN_RST < ARG_LEN_CAP) ? MAX_ARG_LEN_RST : ARG_LEN_CAP);
    localparam logic [ARGS_W-1:0] ARGS_LIM_RST =
        ARGS_W'((MAX_ARGS_RST < ARGS_CAP) ? MAX_ARGS_RST : ARGS_CAP);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARG_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS     = 2'd2;

    // special bytes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;

    typedef enum logic [KIND_W-1:0] {
        KIND_STORED    = 3'd0,
        KIND_SEP       = 3'd1,
        KIND_DROPPED   = 3'd2,
        KIND_IGNORED   = 3'd3,
        KIND_LINE_END  = 3'd4,
        KIND_TRUNC_END = 3'd5
    } kind_t;

    typedef struct packed {
        logic [LINE_W-1:0]    line_lim;
        logic [ARG_LEN_W-1:0] arg_len_lim;
        logic [ARGS_W-1:0]    args_lim;
    } limits_t;

    typedef struct packed {
        kind_t                kind;
        logic [CH_W-1:0]      out_char;
        logic [ASLOT_W-1:0]   arg_slot;
        logic [CSLOT_W-1:0]   char_slot;
        logic                 line_done;
        logic [COUNT_W-1:0]   arg_count;
    } result_t;

endpackage

>>> hw/rtl/clt_cfg_regs.sv
// ----------------------------------------------------------------------------
// clt_cfg_regs
// Limit registers; each write stores the low data bits clamped to capacity.
// ----------------------------------------------------------------------------
module clt_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [clt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clt_pkg::CFG_DATA_W-1:0] cfg_data,
    output clt_pkg::limits_t              limits
);
    import clt_pkg::*;

    logic [LINE_W-1:0]    line_lim_reg;
    logic [ARG_LEN_W-1:0] arg_len_lim_reg;
    logic [ARGS_W-1:0]    args_lim_reg;

    logic [LINE_W-1:0]    line_val;
    logic [ARG_LEN_W-1:0] arg_len_val;
    logic [ARGS_W-1:0]    args_val;

    always_comb begin
        line_val    = cfg_data[LINE_W-1:0];
        arg_len_val = cfg_data[ARG_LEN_W-1:0];
        args_val    = cfg_data[ARGS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_lim_reg    <= LINE_LIM_RST;
            arg_len_lim_reg <= ARG_LEN_LIM_RST;
            args_lim_reg    <= ARGS_LIM_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_MAX_LINE_LEN) begin
                line_lim_reg <= (int'(line_val) < LINE_CAP) ? line_val : LINE_W'(LINE_CAP);
            end
            if (cfg_index == CFG_MAX_ARG_LEN) begin
                arg_len_lim_reg <= (int'(arg_len_val) < ARG_LEN_CAP) ?
                                   arg_len_val : ARG_LEN_W'(ARG_LEN_CAP);
            end
            if (cfg_index == CFG_MAX_ARGS) begin
                args_lim_reg <= (int'(args_val) < ARGS_CAP) ? args_val : ARGS_W'(ARGS_CAP);
            end
        end
    end

    assign limits.line_lim    = line_lim_reg;
    assign limits.arg_len_lim = arg_len_lim_reg;
    assign limits.args_lim    = args_lim_reg;

endmodule

>>> hw/rtl/clt_parser.sv
// ----------------------------------------------------------------------------
// clt_parser
// Line state registers and the per-byte classification.
// ----------------------------------------------------------------------------
module clt_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic [clt_pkg::CH_W-1:0] ch,
    input  clt_pkg::limits_t        limits,
    output clt_pkg::result_t        res
);
    import clt_pkg::*;

    logic [LINE_W-1:0]    line_length_reg, line_length_next;
    logic [ARGS_W-1:0]    arg_counter_reg, arg_counter_next;
    logic [ARG_LEN_W-1:0] char_counter_reg, char_counter_next;
    logic                 parse_stopped_reg, parse_stopped_next;

    logic [LINE_W:0] new_len;
    logic            at_limit;
    logic            is_eol;
    logic            is_sep;

    always_comb begin
        new_len  = {1'b0, line_length_reg} + (LINE_W+1)'(1);
        at_limit = new_len >= {1'b0, limits.line_lim};
        is_eol   = (ch == CH_LF) || (ch == CH_CR);
        is_sep   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_COMMA);

        res = '0;
        line_length_next   = line_length_reg;
        arg_counter_next   = arg_counter_reg;
        char_counter_next  = char_counter_reg;
        parse_stopped_next = parse_stopped_reg;

        priority if (at_limit && ch != CH_LF) begin
            // limit byte is treated as nul: no argument added
            res.kind           = KIND_TRUNC_END;
            res.line_done      = 1'b1;
            res.arg_count      = arg_counter_reg;
            line_length_next   = '0;
            arg_counter_next   = '0;
            char_counter_next  = '0;
            parse_stopped_next = 1'b0;
        end else if (is_eol) begin
            res.kind           = KIND_LINE_END;
            res.line_done      = 1'b1;
            res.arg_count      = parse_stopped_reg ? arg_counter_reg
                                                   : arg_counter_reg + COUNT_W'(1);
            line_length_next   = '0;
            arg_counter_next   = '0;
            char_counter_next  = '0;
            parse_stopped_next = 1'b0;
        end else begin
            line_length_next = new_len[LINE_W-1:0];
            priority if (parse_stopped_reg) begin
                res.kind = KIND_IGNORED;
            end else if (ch == CH_NUL) begin
                res.kind           = KIND_IGNORED;
                parse_stopped_next = 1'b1;
            end else if (is_sep) begin
                res.kind          = KIND_SEP;
                arg_counter_next  = arg_counter_reg + ARGS_W'(1);
                char_counter_next = '0;
            end else if (char_counter_reg < limits.arg_len_lim) begin
                res.kind          = KIND_STORED;
                res.out_char      = ch;
                res.arg_slot      = arg_counter_reg[ASLOT_W-1:0];
                res.char_slot     = char_counter_reg[CSLOT_W-1:0];
                char_counter_next = char_counter_reg + ARG_LEN_W'(1);
            end else begin
                res.kind = KIND_DROPPED;
            end
            if (arg_counter_next >= limits.args_lim) begin
                parse_stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg   <= '0;
            arg_counter_reg   <= '0;
            char_counter_reg  <= '0;
            parse_stopped_reg <= 1'b0;
        end else if (accept) begin
            line_length_reg   <= line_length_next;
            arg_counter_reg   <= arg_counter_next;
            char_counter_reg  <= char_counter_next;
            parse_stopped_reg <= parse_stopped_next;
        end
    end

    a_line_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.line_done |=> line_length_reg == '0 && arg_counter_reg == '0
                                    && char_counter_reg == '0 && !parse_stopped_reg)
        else $error("line state not cleared after line end");

    a_store_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.kind == KIND_STORED |=>
            char_counter_reg == $past(char_counter_reg) + ARG_LEN_W'(1))
        else $error("char position did not advance after stored byte");

    a_stop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        parse_stopped_reg && !accept |=> parse_stopped_reg)
        else $error("parse stop dropped without a byte");

    a_char_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(char_counter_reg) <= ARG_LEN_CAP)
        else $error("char counter beyond argument capacity");

endmodule

>>> hw/rtl/clt_out_skid.sv
// ----------------------------------------------------------------------------
// clt_out_skid
// Result register, one skid entry; input stays open on stall until it fills.
// ----------------------------------------------------------------------------
module clt_out_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  clt_pkg::result_t in_res,
    output logic             out_valid,
    input  logic             out_ready,
    output clt_pkg::result_t out_res
);
    import clt_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_res_reg;
    result_t skid_res_reg;
    logic    take;
    logic    drain;

    assign in_ready = !skid_valid_reg;
    assign take     = in_valid && in_ready;
    assign drain    = out_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (drain) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (take) begin
                if (out_valid_reg && !out_ready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (drain) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg && drain) begin
            out_res_reg <= skid_res_reg;
        end else if (take && (!out_valid_reg || out_ready)) begin
            out_res_reg <= in_res;
        end
        if (take && out_valid_reg && !out_ready) begin
            skid_res_reg <= in_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty result register");

    a_skid_moves_up: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg
                                        && out_res_reg == $past(skid_res_reg))
        else $error("skid entry not moved into result register");

    a_take_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !out_valid_reg |=> out_valid_reg && out_res_reg == $past(in_res))
        else $error("accepted result lost");

endmodule

>>> hw/rtl/command_line_tokenizer_core.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer_core
// Byte-wise command line tokenizer with limit registers and stream ports.
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one received byte per transfer; m_* carries one result per
//   byte: its kind in m_tuser, line end in m_tlast, slot and count in m_tdata.
//   cfg_* writes the three limit registers (0 max line length, 1 max argument
//   length, 2 max argument count); cfg_ready is always high, writes to other
//   indexes are dropped. write the limits only while no byte is in flight.
// output: a result is registered at its byte transfer.
// throughput: one byte per cycle while s_tready is high; the line state
//   registers are the only loop through the classification logic.
// reset: aresetn low for one edge restores the limits (128, 16, 8), clears
//   the line state and empties the output stage.
// stall: when m_tready is low the result register holds and one more byte
//   is taken into a skid entry; s_tready drops only while that entry is full
//   and rises again the cycle after the held result is taken.
// ----------------------------------------------------------------------------
module command_line_tokenizer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [clt_pkg::CH_W-1:0]      s_tdata,   // [7:0] ch
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [clt_pkg::M_DATA_W-1:0]  m_tdata,   // [7:0] out_char, [10:8] arg_slot,
                                                     // [14:11] char_slot, [18:15] arg_count
    output logic [clt_pkg::KIND_W-1:0]    m_tuser,   // [2:0] kind
    output logic                          m_tlast,   // line_done
    // limit register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [clt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import clt_pkg::*;

    limits_t limits;
    result_t parse_res;
    result_t out_res;
    logic    in_ready;
    logic    accept;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // a byte transfer advances the line state and enters the output stage
    assign s_tready = in_ready;
    assign accept   = s_tvalid && in_ready;

    clt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    clt_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .ch      (s_tdata),
        .limits  (limits),
        .res     (parse_res)
    );

    clt_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (in_ready),
        .in_res    (parse_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // pack result fields, lowest field first, zero fill to whole bytes
    assign m_tdata = {5'b0, out_res.arg_count, out_res.char_slot,
                      out_res.arg_slot, out_res.out_char};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.line_done;

    a_done_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_LINE_END || m_tuser == KIND_TRUNC_END)
        else $error("line end flag on a non-ending result");

    a_stored_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STORED |-> !m_tlast && m_tdata[18:15] == '0)
        else $error("stored byte carries line end data");

    a_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

>>> verif/tokenizer_check_pkg.sv
// ----------------------------------------------------------------------------
// tokenizer_check_pkg
// Checks the tokenizer's results. It keeps its own copy of the limits and of
// the line state, works out the result of every byte the block takes, and
// compares each result the block delivers with the oldest one waiting.
// ----------------------------------------------------------------------------
package tokenizer_check_pkg;

    import clt_pkg::*;

    class token_tracker;

        // limit registers as written
        logic [LINE_W-1:0]    max_line_len;
        logic [ARG_LEN_W-1:0] max_arg_len;
        logic [ARGS_W-1:0]    max_args;

        // line state
        logic [LINE_W-1:0]    line_length;
        logic [ARGS_W-1:0]    arg_counter;
        logic [ARG_LEN_W-1:0] char_counter;
        logic                 parse_stopped;

        result_t expected_tokens[$];
        int      mismatches;

        function new();
            max_line_len = LINE_W'(MAX_LINE_LEN_RST);
            max_arg_len  = ARG_LEN_W'(MAX_ARG_LEN_RST);
            max_args     = ARGS_W'(MAX_ARGS_RST);
            mismatches   = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_length   = '0;
            arg_counter   = '0;
            char_counter  = '0;
            parse_stopped = 1'b0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MAX_LINE_LEN: max_line_len = val[LINE_W-1:0];
                CFG_MAX_ARG_LEN:  max_arg_len  = val[ARG_LEN_W-1:0];
                CFG_MAX_ARGS:     max_args     = val[ARGS_W-1:0];
                default: ;
            endcase
        endfunction

        // classify one byte and advance the line state
        function result_t classify_byte(logic [CH_W-1:0] c);
            result_t r;
            int      line_lim;
            int      arg_len_lim;
            int      args_lim;
            int      next_len;
            r           = '0;
            line_lim    = (max_line_len < LINE_CAP) ? max_line_len : LINE_CAP;
            arg_len_lim = (max_arg_len < ARG_LEN_CAP) ? max_arg_len : ARG_LEN_CAP;
            args_lim    = (max_args < ARGS_CAP) ? max_args : ARGS_CAP;
            next_len    = line_length + 1;
            if (next_len >= line_lim && c != CH_LF) begin
                // the byte at the length limit acts as nul
                r.kind      = KIND_TRUNC_END;
                r.line_done = 1'b1;
                r.arg_count = arg_counter;
                clear_line();
            end else if (c == CH_LF || c == CH_CR) begin
                r.kind      = KIND_LINE_END;
                r.line_done = 1'b1;
                r.arg_count = parse_stopped ? arg_counter : arg_counter + 4'd1;
                clear_line();
            end else begin
                line_length = next_len[LINE_W-1:0];
                if (parse_stopped) begin
                    r.kind = KIND_IGNORED;
                end else if (c == CH_NUL) begin
                    r.kind        = KIND_IGNORED;
                    parse_stopped = 1'b1;
                end else if (c == CH_SPACE || c == CH_TAB || c == CH_COMMA) begin
                    r.kind       = KIND_SEP;
                    arg_counter  = arg_counter + 1'b1;
                    char_counter = '0;
                end else if (char_counter < arg_len_lim) begin
                    r.kind       = KIND_STORED;
                    r.out_char   = c;
                    r.arg_slot   = arg_counter[ASLOT_W-1:0];
                    r.char_slot  = char_counter[CSLOT_W-1:0];
                    char_counter = char_counter + 1'b1;
                end else begin
                    r.kind = KIND_DROPPED;
                end
                if (arg_counter >= args_lim)
                    parse_stopped = 1'b1;
            end
            return r;
        endfunction

        function void note_byte(logic [CH_W-1:0] c);
            expected_tokens.push_back(classify_byte(c));
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        task check_result(logic [KIND_W-1:0] kind_bits,
                          logic [M_DATA_W-1:0] data, logic last);
            result_t exp;
            if (expected_tokens.size() == 0) begin
                report($sformatf("result with no byte waiting, kind %0d", kind_bits));
                return;
            end
            exp = expected_tokens.pop_front();
            if (kind_bits !== exp.kind)
                report($sformatf("kind %0d, expected %0d", kind_bits, exp.kind));
            if (data[7:0] !== exp.out_char)
                report($sformatf("out_char %h, expected %h", data[7:0], exp.out_char));
            if (data[10:8] !== exp.arg_slot)
                report($sformatf("arg_slot %0d, expected %0d", data[10:8], exp.arg_slot));
            if (data[14:11] !== exp.char_slot)
                report($sformatf("char_slot %0d, expected %0d", data[14:11], exp.char_slot));
            if (data[18:15] !== exp.arg_count)
                report($sformatf("arg_count %0d, expected %0d", data[18:15], exp.arg_count));
            if (data[M_DATA_W-1:19] !== '0)
                report($sformatf("tdata padding %h not zero", data[M_DATA_W-1:19]));
            if (last !== exp.line_done)
                report($sformatf("tlast %b, expected %b", last, exp.line_done));
        endtask

        task check_drained();
            if (expected_tokens.size() != 0)
                report($sformatf("%0d results never arrived", expected_tokens.size()));
        endtask

    endclass

endpackage

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the command line tokenizer. Directed lines cover
// separators, nul, line ends and the length and argument limits; random
// lines follow under several limit settings, with random gaps on the input
// and random back-pressure on the results. Every result is checked against
// an independent prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import clt_pkg::*;
    import tokenizer_check_pkg::*;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // byte stream
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [CH_W-1:0]       s_tdata  = '0;

    // result stream
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    // limit writes
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // idling switches, per phase
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    int          bytes_sent = 0;
    int unsigned stall_left = 0;

    token_tracker tracker = new();

    always #4 aclk = ~aclk;

    command_line_tokenizer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // receiver back-pressure: random stall bursts while rx_idle is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checking on every accepted transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tuser, m_tdata, m_tlast);
    end

    // one byte transfer, with an optional gap in front
    task automatic send_byte(input logic [CH_W-1:0] ch);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        // byte taken at this edge, predict its result now
        tracker.note_byte(ch);
        bytes_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
    endtask

    // hold the sender until every predicted result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // keeps cfg_valid high; the caller lowers it after the last write
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_limit(idx, val);
    endtask

    task automatic apply_limits(input logic [CFG_DATA_W-1:0] line_val,
                                input logic [CFG_DATA_W-1:0] arg_len_val,
                                input logic [CFG_DATA_W-1:0] args_val);
        wait_drained();
        write_limit(CFG_MAX_LINE_LEN, line_val);
        write_limit(CFG_MAX_ARG_LEN, arg_len_val);
        write_limit(CFG_MAX_ARGS, args_val);
        cfg_valid <= 1'b0;
    endtask

    // mostly printable word bytes, some separators and nul, some any byte
    function automatic logic [CH_W-1:0] word_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            case ($urandom_range(0, 2))
                0:       return CH_SPACE;
                1:       return CH_TAB;
                default: return CH_COMMA;
            endcase
        end
        if (pick < 17)
            return CH_NUL;
        if (pick < 27)
            return CH_W'($urandom_range(0, 255));
        return CH_W'($urandom_range(8'h21, 8'h7E));
    endfunction

    // one line: random body, then lf, cr or nothing (later bytes end it)
    task automatic send_line(input int body_max);
        int body_len;
        int ending;
        bit noise;
        body_len = $urandom_range(0, body_max);
        noise    = ($urandom_range(0, 9) == 0);
        repeat (body_len)
            send_byte(noise ? CH_W'($urandom_range(0, 255)) : word_byte());
        ending = $urandom_range(0, 9);
        if (ending < 4)
            send_byte(CH_LF);
        else if (ending < 8)
            send_byte(CH_CR);
    endtask

    // long lines run past the length limit now and then
    task automatic random_lines(input int n_bytes, input int span, input int long_max);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_line(($urandom_range(0, 7) == 0) ? long_max : span);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limits: stored, separators, empty args, extreme bytes, cr end,
        // nul stopping the line, lf end
        send_text("ab \tc,,");
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_text("q");
        send_byte(CH_NUL);
        send_text("z,\n");
        send_byte(8'h7F);
        send_byte(CH_LF);
        wait_drained();
        random_lines(220, 30, 131);

        // small limits: two-byte lines, one-byte args, one arg
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        apply_limits(8'd2, 8'd1, 8'd1);
        random_lines(120, 3, 5);

        // dropped bytes, argument limit, lf landing on the length limit
        rx_idle = 1'b1;
        tx_idle = 1'b0;
        apply_limits(8'd12, 8'd1, 8'd2);
        send_text("abc d u,v,w\n");
        random_lines(150, 14, 15);

        // zero limits: every byte ends the line
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        apply_limits(8'd0, 8'd0, 8'd0);
        random_lines(60, 3, 4);

        // all ones: every limit above its capacity
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        apply_limits(8'hFF, 8'hFF, 8'hFF);
        random_lines(75, 30, 131);
        wait_drained();
        random_lines(75, 30, 131);

        // line limit of one
        apply_limits(8'd1, 8'd16, 8'd8);
        random_lines(40, 3, 4);

        apply_limits(8'd40, 8'd4, 8'd3);
        random_lines(200, 45, 43);

        // back to the capacities, no idling on either side
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        apply_limits(8'd128, 8'd16, 8'd8);
        random_lines(200, 40, 131);

        wait_drained();
        repeat (4) @(posedge aclk);
        tracker.check_drained();
        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
